>>> hdl/mlep_pkg.sv
`timescale 1ns / 1ps

package mlep_pkg;

	localparam int POOL_ENTRIES_DEF = 1024;
	localparam int LIST_COUNT_DEF   = 6;

	localparam int OP_W       = 2;
	localparam int LIST_W     = 3;
	localparam int STATUS_W   = 2;
	localparam int RESERVE_W  = 11;
	localparam int WRAP_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [RESERVE_W-1:0] MISC_RESERVE_RST = 11'h12C;
	localparam logic [LIST_W-1:0]    MISC_LIST_RST    = 3'd3;
	localparam logic [LIST_W-1:0]    GENERAL_LIST_RST = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_MISC_RESERVE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MISC_LIST    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GENERAL_LIST = 2'd2;

	localparam logic [LIST_W-1:0] FREE_LIST = 3'd0;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_MOVE  = 2'd1,
		OP_FREE  = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_REFUSED = 2'd2,
		ST_BAD     = 2'd3
	} status_t;

endpackage

>>> hdl/multi_list_entry_pool.sv
`timescale 1ns / 1ps

// channel   | ports                                              | handshake
// ----------+----------------------------------------------------+---------------------------
// command   | operation, entry_index, target_list, reserve_check | taken when start & !busy
// result    | status                                             | done high for one cycle
// config    | wr_index, wr_data                                  | written when wr_en high
//
// A relinking item runs check, read, unlink-prev, unlink-next, link-entry and link-old-head
// states before done; a refused, empty or bad item ends in check. The single port on each
// link table (next, prev, tag) sets the step count. After reset a clearing pass writes
// every link table entry with busy high. busy drops in the cycle done is shown, so a new
// item may start then. The receiver cannot stall: done is a one-cycle strobe.

module multi_list_entry_pool import mlep_pkg::*; #(
	parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
	parameter int LIST_COUNT   = LIST_COUNT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [OP_W-1:0]              operation,
	input  logic [$clog2(POOL_ENTRIES)-1:0] entry_index,
	input  logic [LIST_W-1:0]            target_list,
	input  logic                         reserve_check,
	output logic                         done,
	output logic [STATUS_W-1:0]          status,
	input  logic                         wr_en,
	input  logic [CFG_IDX_W-1:0]         wr_index,
	input  logic [CFG_DATA_W-1:0]        wr_data
);

	localparam int IDX_W      = $clog2(POOL_ENTRIES);
	localparam int LINK_W     = $clog2(POOL_ENTRIES + 1);
	localparam int LIST_IDX_W = $clog2(LIST_COUNT);
	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_ENTRIES);
	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(POOL_ENTRIES - 1);

	typedef enum logic [7:0] {
		S_INIT     = 8'b0000_0001,
		S_IDLE     = 8'b0000_0010,
		S_CHECK    = 8'b0000_0100,
		S_READ     = 8'b0000_1000,
		S_UNLINK_P = 8'b0001_0000,
		S_UNLINK_N = 8'b0010_0000,
		S_LINK_E   = 8'b0100_0000,
		S_LINK_OH  = 8'b1000_0000
	} state_t;

	state_t                  state_q;
	logic [IDX_W-1:0]        init_q;
	op_t                     op_q;
	logic [IDX_W-1:0]        e_q;
	logic [LIST_W-1:0]       tl_q;
	logic                    rc_q;
	logic [LIST_IDX_W-1:0]   dst_q;
	logic [LIST_IDX_W-1:0]   src_q;
	logic [LINK_W-1:0]       nx_q;
	logic [LINK_W-1:0]       pv_q;
	logic [LINK_W-1:0]       oh_q;
	logic [RESERVE_W-1:0]    misc_reserve_q;
	logic [LIST_W-1:0]       misc_list_q;
	logic [LIST_W-1:0]       general_list_q;
	logic                    done_q;
	status_t                 status_q;

	logic [LINK_W-1:0]       head_q  [LIST_COUNT];
	logic [LINK_W-1:0]       count_q [LIST_COUNT];

	logic [LINK_W-1:0]       next_mem [POOL_ENTRIES];
	logic [LINK_W-1:0]       prev_mem [POOL_ENTRIES];
	logic [LIST_IDX_W-1:0]   tag_mem  [POOL_ENTRIES];
	logic [LINK_W-1:0]       next_rd_q;
	logic [LINK_W-1:0]       prev_rd_q;
	logic [LIST_IDX_W-1:0]   tag_rd_q;

	logic                    next_we, prev_we, tag_we;
	logic [IDX_W-1:0]        next_wa, prev_wa, tag_wa;
	logic [LINK_W-1:0]       next_wd, prev_wd;
	logic [LIST_IDX_W-1:0]   tag_wd;

	logic [LIST_W-1:0]       req_dst;
	logic                    dst_ok;
	logic                    e_ok;
	logic [LINK_W-1:0]       cnt_dst;
	logic [WRAP_W-1:0]       reserve_gap;
	logic                    refused;

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign status = status_q;

	// check stage: destination list, index range, reserve rule
	always_comb begin
		case (op_q)
			OP_ALLOC: req_dst = rc_q ? misc_list_q : general_list_q;
			OP_MOVE:  req_dst = tl_q;
			default:  req_dst = FREE_LIST;
		endcase
		dst_ok      = ({1'b0, req_dst} < (LIST_W + 1)'(LIST_COUNT));
		e_ok        = (LINK_W'(e_q) < NULL_LINK);
		cnt_dst     = dst_ok ? count_q[req_dst[LIST_IDX_W-1:0]] : '0;
		reserve_gap = WRAP_W'(misc_reserve_q) - WRAP_W'(cnt_dst);
		refused     = (reserve_gap >= WRAP_W'(count_q[0]));
	end

	// link table write ports
	always_comb begin
		next_we = 1'b0;
		next_wa = e_q;
		next_wd = oh_q;
		prev_we = 1'b0;
		prev_wa = e_q;
		prev_wd = NULL_LINK;
		tag_we  = 1'b0;
		tag_wa  = e_q;
		tag_wd  = dst_q;
		case (state_q)
			S_INIT: begin
				next_we = 1'b1;
				next_wa = init_q;
				next_wd = LINK_W'(init_q) + LINK_W'(1);
				prev_we = 1'b1;
				prev_wa = init_q;
				prev_wd = (init_q == '0) ? NULL_LINK : LINK_W'(init_q) - LINK_W'(1);
				tag_we  = 1'b1;
				tag_wa  = init_q;
				tag_wd  = '0;
			end
			S_UNLINK_P: begin
				next_wa = prev_rd_q[IDX_W-1:0];
				next_wd = next_rd_q;
				next_we = (tag_rd_q != dst_q) && (prev_rd_q != NULL_LINK);
			end
			S_UNLINK_N: begin
				prev_wa = nx_q[IDX_W-1:0];
				prev_wd = pv_q;
				prev_we = (nx_q != NULL_LINK);
			end
			S_LINK_E: begin
				next_we = 1'b1;
				prev_we = 1'b1;
				tag_we  = 1'b1;
			end
			S_LINK_OH: begin
				prev_wa = oh_q[IDX_W-1:0];
				prev_wd = LINK_W'(e_q);
				prev_we = (oh_q != NULL_LINK);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		next_rd_q <= next_mem[e_q];
	end

	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		prev_rd_q <= prev_mem[e_q];
	end

	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[tag_wa] <= tag_wd;
		end
		tag_rd_q <= tag_mem[e_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			misc_reserve_q <= MISC_RESERVE_RST;
			misc_list_q    <= MISC_LIST_RST;
			general_list_q <= GENERAL_LIST_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_MISC_RESERVE: misc_reserve_q <= wr_data[RESERVE_W-1:0];
				CFG_MISC_LIST:    misc_list_q    <= wr_data[LIST_W-1:0];
				CFG_GENERAL_LIST: general_list_q <= wr_data[LIST_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			init_q   <= '0;
			op_q     <= OP_ALLOC;
			e_q      <= '0;
			tl_q     <= '0;
			rc_q     <= 1'b0;
			dst_q    <= '0;
			src_q    <= '0;
			nx_q     <= '0;
			pv_q     <= '0;
			oh_q     <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			for (int i = 0; i < LIST_COUNT; i++) begin
				head_q[i]  <= (i == 0) ? '0 : NULL_LINK;
				count_q[i] <= (i == 0) ? NULL_LINK : '0;
			end
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_INIT: begin
					init_q <= init_q + IDX_W'(1);
					if (init_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q    <= op_t'(operation);
						e_q     <= entry_index;
						tl_q    <= target_list;
						rc_q    <= reserve_check;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					dst_q <= req_dst[LIST_IDX_W-1:0];
					case (op_q)
						OP_ALLOC: begin
							if (!dst_ok || req_dst == FREE_LIST) begin
								status_q <= ST_BAD;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else if (rc_q && refused) begin
								status_q <= ST_REFUSED;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else if (count_q[0] == '0 || head_q[0] == NULL_LINK) begin
								status_q <= ST_EMPTY;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								e_q     <= head_q[0][IDX_W-1:0];
								state_q <= S_READ;
							end
						end
						OP_MOVE, OP_FREE: begin
							if (!e_ok || !dst_ok) begin
								status_q <= ST_BAD;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								state_q <= S_READ;
							end
						end
						default: begin
							status_q <= ST_BAD;
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
						end
					endcase
				end
				S_READ: begin
					state_q <= S_UNLINK_P;
				end
				S_UNLINK_P: begin
					if (tag_rd_q == dst_q) begin
						status_q <= ST_OK;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						src_q <= tag_rd_q;
						nx_q  <= next_rd_q;
						pv_q  <= prev_rd_q;
						oh_q  <= head_q[dst_q];
						if (prev_rd_q == NULL_LINK) begin
							head_q[tag_rd_q] <= next_rd_q;
						end
						state_q <= S_UNLINK_N;
					end
				end
				S_UNLINK_N: begin
					count_q[src_q] <= count_q[src_q] - LINK_W'(1);
					state_q        <= S_LINK_E;
				end
				S_LINK_E: begin
					head_q[dst_q]  <= LINK_W'(e_q);
					count_q[dst_q] <= count_q[dst_q] + LINK_W'(1);
					state_q        <= S_LINK_OH;
				end
				S_LINK_OH: begin
					status_q <= ST_OK;
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> sim/multi_list_entry_pool_tb.sv
`timescale 1ns / 1ps

module multi_list_entry_pool_tb;
	import mlep_pkg::*;

	localparam int NENT   = POOL_ENTRIES_DEF;
	localparam int NLIST  = LIST_COUNT_DEF;
	localparam int IDX_W  = $clog2(NENT);
	localparam int LINK_W = IDX_W + 1;
	localparam int LIMIT  = 400000;
	localparam int PHASES = 6;
	localparam logic [LINK_W-1:0] NIL = LINK_W'(NENT);
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [IDX_W-1:0]  idx;
		logic [LIST_W-1:0] tl;
		logic              rc;
		logic              typed;
		status_t           st;
	} cmd_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [OP_W-1:0]       operation;
	logic [IDX_W-1:0]      entry_index;
	logic [LIST_W-1:0]     target_list;
	logic                  reserve_check;
	logic                  done;
	logic [STATUS_W-1:0]   status;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	// shadow of the pool
	logic [LINK_W-1:0]    nxt_tab [NENT];
	logic [LINK_W-1:0]    prv_tab [NENT];
	logic [LIST_W-1:0]    tag_tab [NENT];
	logic [LINK_W-1:0]    head_tab [NLIST];
	logic [LINK_W-1:0]    cnt_tab [NLIST];
	logic [RESERVE_W-1:0] m_reserve;
	logic [LIST_W-1:0]    m_misc;
	logic [LIST_W-1:0]    m_general;

	status_t  status_due [$];
	status_t  due_head;
	cmd_row_t dir_rows [$];
	int       mismatch_count = 0;
	int       items_sent = 0;
	int       cycle_count = 0;
	int       result_tally [4] = '{0, 0, 0, 0};

	int ph_reserve [PHASES] = '{300, 0, 1024, 2047, 150, 1};
	int ph_misc    [PHASES] = '{3, 1, 5, 7, 2, 0};
	int ph_general [PHASES] = '{5, 2, 1, 0, 4, 6};
	int ph_items   [PHASES] = '{200, 150, 1100, 100, 250, 50};
	int ph_alloc   [PHASES] = '{40, 50, 95, 20, 35, 50};
	int ph_free    [PHASES] = '{20, 20, 2, 70, 40, 25};
	int ph_rc      [PHASES] = '{50, 60, 25, 50, 50, 50};

	multi_list_entry_pool DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.entry_index(entry_index),
		.target_list(target_list),
		.reserve_check(reserve_check),
		.done(done),
		.status(status),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	task automatic report_mismatch(string what);
		$display("ERROR @%0t: %s", $time, what);
		mismatch_count++;
	endtask

	function automatic void shadow_reset();
		for (int i = 0; i < NENT; i++) begin
			nxt_tab[i] = (i + 1 < NENT) ? LINK_W'(i + 1) : NIL;
			prv_tab[i] = (i == 0) ? NIL : LINK_W'(i - 1);
			tag_tab[i] = FREE_LIST;
		end
		for (int l = 0; l < NLIST; l++) begin
			head_tab[l] = NIL;
			cnt_tab[l] = '0;
		end
		head_tab[0] = '0;
		cnt_tab[0] = LINK_W'(NENT);
		m_reserve = MISC_RESERVE_RST;
		m_misc = MISC_LIST_RST;
		m_general = GENERAL_LIST_RST;
	endfunction

	function automatic void relink_entry(int e, int dst);
		int src;
		int nx;
		int pv;
		int oh;
		src = tag_tab[e];
		if (src == dst)
			return;
		nx = nxt_tab[e];
		pv = prv_tab[e];
		if (pv < NENT)
			nxt_tab[pv] = LINK_W'(nx);
		else
			head_tab[src] = LINK_W'(nx);
		if (nx < NENT)
			prv_tab[nx] = LINK_W'(pv);
		oh = head_tab[dst];
		prv_tab[e] = NIL;
		nxt_tab[e] = LINK_W'(oh);
		tag_tab[e] = LIST_W'(dst);
		head_tab[dst] = LINK_W'(e);
		if (oh < NENT)
			prv_tab[oh] = LINK_W'(e);
		cnt_tab[src] = cnt_tab[src] - LINK_W'(1);
		cnt_tab[dst] = cnt_tab[dst] + LINK_W'(1);
	endfunction

	function automatic status_t pool_apply(logic [OP_W-1:0] op, int e, int tl, bit rc);
		int dst;
		logic [WRAP_W-1:0] gap;
		case (op)
			OP_ALLOC: begin
				dst = rc ? m_misc : m_general;
				if (dst == 0 || dst >= NLIST)
					return ST_BAD;
				if (rc) begin
					// 16-bit wrap: misc count above the reserve gives a huge gap
					gap = WRAP_W'(m_reserve) - WRAP_W'(cnt_tab[dst]);
					if (gap >= WRAP_W'(cnt_tab[0]))
						return ST_REFUSED;
				end else if (cnt_tab[0] == 0) begin
					return ST_EMPTY;
				end
				if (head_tab[0] >= NENT)
					return ST_EMPTY;
				relink_entry(head_tab[0], dst);
				return ST_OK;
			end
			OP_MOVE, OP_FREE: begin
				dst = (op == OP_FREE) ? FREE_LIST : tl;
				if (dst >= NLIST)
					return ST_BAD;
				relink_entry(e, dst);
				return ST_OK;
			end
			default: return ST_BAD;
		endcase
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		@(negedge clk);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = CFG_DATA_W'(value);
		@(posedge clk);
		case (idx)
			CFG_MISC_RESERVE: m_reserve = RESERVE_W'(value);
			CFG_MISC_LIST:    m_misc = LIST_W'(value);
			CFG_GENERAL_LIST: m_general = LIST_W'(value);
			default: ;
		endcase
	endtask

	task automatic drain();
		do @(posedge clk); while (status_due.size() != 0 || busy);
	endtask

	task automatic issue(cmd_row_t row, bit quiet);
		status_t st;
		@(negedge clk);
		if (!quiet)
			while ($urandom_range(0, 99) < 16) begin
				start = 1'b0;
				@(negedge clk);
			end
		operation = row.op;
		entry_index = row.idx;
		target_list = row.tl;
		reserve_check = row.rc;
		start = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		st = pool_apply(row.op, row.idx, row.tl, row.rc);
		status_due.push_back(row.typed ? row.st : st);
		items_sent++;
	endtask

	function automatic void add_row(logic [OP_W-1:0] op, int idx, int tl, bit rc,
		bit typed, status_t st);
		cmd_row_t row;
		row.op = op;
		row.idx = IDX_W'(idx);
		row.tl = LIST_W'(tl);
		row.rc = rc;
		row.typed = typed;
		row.st = st;
		dir_rows.push_back(row);
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (status_due.size() == 0) begin
				report_mismatch($sformatf("status %0d with nothing pending", status));
			end else begin
				due_head = status_due.pop_front();
				if (status !== due_head)
					report_mismatch($sformatf("status %0d, predicted %0d",
						status, due_head));
			end
			if (!$isunknown(status))
				result_tally[status]++;
		end
	end

	initial begin
		cmd_row_t row;
		int r;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_ALLOC;
		entry_index = '0;
		target_list = '0;
		reserve_check = 1'b0;
		wr_en = 1'b0;
		wr_index = CFG_MISC_RESERVE;
		wr_data = '0;
		shadow_reset();

		// reset defaults: reserve 300, misc 3, general 5, pool full
		add_row(OP_FREE, 0, 0, 0, 1, ST_OK);
		add_row(OP_MOVE, 5, 6, 0, 1, ST_BAD);
		add_row(OP_MOVE, 5, 7, 1, 1, ST_BAD);
		add_row(OP_UNUSED, 1023, 7, 1, 1, ST_BAD);
		add_row(OP_ALLOC, 0, 0, 0, 1, ST_OK);
		add_row(OP_ALLOC, 0, 0, 1, 1, ST_OK);
		add_row(OP_MOVE, 1023, 2, 0, 1, ST_OK);
		add_row(OP_MOVE, 1023, 2, 1, 1, ST_OK);
		add_row(OP_MOVE, 0, 0, 0, 1, ST_OK);
		add_row(OP_MOVE, 1, 4, 0, 1, ST_OK);
		add_row(OP_MOVE, 1, 1, 0, 0, ST_OK);
		add_row(OP_FREE, 1, 3, 1, 1, ST_OK);
		add_row(OP_FREE, 1023, 0, 0, 1, ST_OK);
		add_row(OP_MOVE, 512, 3, 0, 0, ST_OK);
		add_row(OP_MOVE, 513, 3, 0, 0, ST_OK);
		add_row(OP_MOVE, 514, 3, 0, 0, ST_OK);
		add_row(OP_FREE, 513, 0, 0, 0, ST_OK);
		add_row(OP_ALLOC, 1023, 7, 1, 0, ST_OK);
		add_row(OP_ALLOC, 682, 5, 0, 0, ST_OK);
		add_row(OP_MOVE, 341, 5, 1, 0, ST_OK);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// clearing pass after reset
		do @(posedge clk); while (busy);

		foreach (dir_rows[i])
			issue(dir_rows[i], 1'b0);
		@(negedge clk);
		start = 1'b0;

		for (int p = 0; p < PHASES; p++) begin
			drain();
			write_reg(CFG_MISC_RESERVE, ph_reserve[p]);
			write_reg(CFG_MISC_LIST, ph_misc[p]);
			write_reg(CFG_GENERAL_LIST, ph_general[p]);
			@(negedge clk);
			wr_en = 1'b0;
			for (int n = 0; n < ph_items[p]; n++) begin
				r = $urandom_range(0, 99);
				row.idx = IDX_W'($urandom_range(0, NENT - 1));
				row.tl = LIST_W'($urandom_range(0, NLIST - 1));
				row.rc = ($urandom_range(0, 99) < ph_rc[p]);
				row.typed = 1'b0;
				row.st = ST_OK;
				if (r < ph_alloc[p])
					row.op = OP_ALLOC;
				else if (r < ph_alloc[p] + ph_free[p])
					row.op = OP_FREE;
				else if (r < 97)
					row.op = OP_MOVE;
				else if (r < 99) begin
					row.op = OP_MOVE;
					row.tl = LIST_W'($urandom_range(NLIST, 7));
				end else
					row.op = OP_UNUSED;
				// back-to-back stretch in the long allocation phase
				issue(row, p == 2 && n >= 100 && n < 500);
			end
			@(negedge clk);
			start = 1'b0;
		end

		drain();
		repeat (20) @(posedge clk);
		$display("Sent %0d items over %0d register settings.", items_sent, PHASES + 1);
		$display("Statuses seen: ok %0d, empty %0d, refused %0d, bad %0d; %0d mismatches.",
			result_tally[0], result_tally[1], result_tally[2], result_tally[3],
			mismatch_count);
		if (mismatch_count == 0 && status_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> sim.f
hdl/mlep_pkg.sv
hdl/multi_list_entry_pool.sv
sim/multi_list_entry_pool_tb.sv
